[hw/rtl/csvt_pkg.sv]
// Shared types, character codes and token helpers for the CSV row tokenizer.
// No dependencies; imported by every RTL file of the block.
`timescale 1ns / 1ps

package csvt_pkg;

  localparam int MaxTokens = 4;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_KEPT  = 2'd2,
    KIND_ROW_DROP  = 2'd3
  } token_kind_t;

  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_BSLASH = 2'd1,
    PEND_SLASH  = 2'd2
  } pend_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] token_byte;
    logic       run_end;
  } out_t;

  typedef struct packed {
    token_kind_t kind;
    logic [7:0]  data;
  } token_t;

  typedef struct packed {
    logic [2:0]                 count;
    token_t [MaxTokens-1:0]     item;
  } token_list_t;

  typedef struct packed {
    logic  quoted_mode;
    pend_t pending_char;
    logic  skipping_row;
    logic  separator_seen;
    logic  field_nonempty;
  } tok_state_t;

  function automatic token_list_t push_token(token_list_t l, token_kind_t kind,
                                             logic [7:0] data);
    token_list_t r;
    r = l;
    if (l.count < 3'(MaxTokens)) begin
      r.item[l.count[1:0]].kind = kind;
      r.item[l.count[1:0]].data = data;
      r.count = 3'(l.count + 3'd1);
    end
    return r;
  endfunction

endpackage

[hw/rtl/csvt_step.sv]
// Combinational next-state and token generation for one text byte.
// Depends on csvt_pkg.
`timescale 1ns / 1ps

module csvt_step
  import csvt_pkg::*;
(
  input  tok_state_t  state,
  input  logic        comments_enabled,
  input  in_t         item,
  output tok_state_t  state_next,
  output token_list_t tokens
);

  always_comb begin
    tok_state_t  s;
    token_list_t l;
    logic [7:0]  c;
    logic        do_plain;
    logic        drop;

    s        = state;
    l        = '0;
    c        = item.text_byte;
    do_plain = 1'b0;
    drop     = 1'b0;

    if (c != CH_LF) begin
      unique case (s.pending_char)
        PEND_BSLASH: begin
          s.pending_char = PEND_NONE;
          if (c == CH_QUOTE) begin
            l = push_token(l, KIND_BYTE, CH_QUOTE);
            s.field_nonempty = 1'b1;
          end else begin
            l = push_token(l, KIND_BYTE, CH_BSLASH);
            s.field_nonempty = 1'b1;
            do_plain = 1'b1;
          end
        end
        PEND_SLASH: begin
          s.pending_char = PEND_NONE;
          if (c == CH_SLASH) begin
            s.skipping_row = 1'b1;
          end else begin
            l = push_token(l, KIND_BYTE, CH_SLASH);
            s.field_nonempty = 1'b1;
            do_plain = 1'b1;
          end
        end
        default: begin
          s.pending_char = PEND_NONE;
          do_plain = 1'b1;
        end
      endcase

      if (do_plain && !s.skipping_row) begin
        priority if (c == CH_COMMA && !s.quoted_mode) begin
          l = push_token(l, KIND_FIELD_END, 8'd0);
          s.separator_seen = 1'b1;
          s.field_nonempty = 1'b0;
        end else if (c == CH_QUOTE) begin
          s.quoted_mode = !s.quoted_mode;
        end else if (s.quoted_mode && c == CH_BSLASH) begin
          s.pending_char = PEND_BSLASH;
        end else if (!s.quoted_mode && (c == CH_CR || c == CH_TAB)) begin
          s.pending_char = PEND_NONE;
        end else if (!s.quoted_mode && comments_enabled && c == CH_HASH) begin
          s.skipping_row = 1'b1;
        end else if (!s.quoted_mode && comments_enabled && c == CH_SLASH) begin
          s.pending_char = PEND_SLASH;
        end else begin
          l = push_token(l, KIND_BYTE, c);
          s.field_nonempty = 1'b1;
        end
      end
    end

    // row end: flush held lookahead byte, then one kept/dropped token
    if (c == CH_LF || item.final_byte) begin
      if (s.pending_char == PEND_BSLASH) begin
        l = push_token(l, KIND_BYTE, CH_BSLASH);
        s.field_nonempty = 1'b1;
      end else if (s.pending_char == PEND_SLASH) begin
        l = push_token(l, KIND_BYTE, CH_SLASH);
        s.field_nonempty = 1'b1;
      end
      drop = s.skipping_row || (!s.separator_seen && !s.field_nonempty);
      l = push_token(l, drop ? KIND_ROW_DROP : KIND_ROW_KEPT, 8'd0);
      s = '0;
    end

    state_next = s;
    tokens     = l;
  end

endmodule

[hw/rtl/csv_row_tokenizer_core.sv]
// CSV row tokenizer top level: input register, tokenizer state, token buffer.
// Depends on csvt_pkg and csvt_step.
`timescale 1ns / 1ps
//
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  in      | in_valid, in_ready, in_data     | sink
//  out     | out_valid, out_ready, out_data  | source
//  cfg     | cfg_we, cfg_data                | sink, write only
//
// A byte is registered on accept and decoded combinationally into 0..3 tokens.
// Tokens leave the token buffer one per cycle while out_ready is high.
// A new byte is taken while the previous one's tokens are still delivered.
// rst is synchronous: it clears tokenizer state, buffers and comments_enabled.

module csv_row_tokenizer_core
  import csvt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data,
  input  logic cfg_we,
  input  logic cfg_data
);

  logic        comments_enabled;
  in_t         item;
  logic        item_valid;
  tok_state_t  state;
  tok_state_t  state_next;
  token_list_t tokens;
  token_list_t token_buf;
  logic        buf_valid;
  logic [1:0]  rd_ptr;
  logic        last_tok;
  logic        last_drain;
  logic        load;

  csvt_step u_step (
    .state            (state),
    .comments_enabled (comments_enabled),
    .item             (item),
    .state_next       (state_next),
    .tokens           (tokens)
  );

  assign last_tok   = (3'({1'b0, rd_ptr}) == 3'(token_buf.count - 3'd1));
  assign last_drain = buf_valid && out_ready && last_tok;
  assign load       = item_valid && (!buf_valid || last_drain);
  assign in_ready   = !item_valid || load;

  assign out_valid           = buf_valid;
  assign out_data.token_kind = token_buf.item[rd_ptr].kind;
  assign out_data.token_byte = token_buf.item[rd_ptr].data;
  assign out_data.run_end    = last_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      comments_enabled <= 1'b0;
    end else if (cfg_we) begin
      comments_enabled <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (load) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      buf_valid <= 1'b0;
      rd_ptr    <= '0;
      token_buf <= '0;
    end else begin
      if (load) begin
        state <= state_next;
      end
      if (load && tokens.count != 3'd0) begin
        token_buf <= tokens;
        buf_valid <= 1'b1;
        rd_ptr    <= '0;
      end else if (buf_valid && out_ready) begin
        if (last_tok) begin
          buf_valid <= 1'b0;
        end else begin
          rd_ptr <= 2'(rd_ptr + 2'd1);
        end
      end
    end
  end

endmodule

[hw/rtl/csvt_checker.sv]
// Port-level checks for csv_row_tokenizer_core, attached by bind.
// Depends on csvt_pkg.
`timescale 1ns / 1ps

module csvt_checker
  import csvt_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // stalled request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output request changed while stalled");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.token_kind != KIND_BYTE |-> out_data.token_byte == 8'd0)
    else $error("non-byte token carries a byte");

  a_row_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.token_kind == KIND_ROW_KEPT ||
                  out_data.token_kind == KIND_ROW_DROP) |-> out_data.run_end)
    else $error("row end token not last of its run");

  // tokens of one byte leave without gaps
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.run_end |=> out_valid)
    else $error("gap inside a token run");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output request right after reset");

endmodule

bind csv_row_tokenizer_core csvt_checker u_csvt_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
